// ===== hdl/mh_pkg.sv =====
`default_nettype none

package mh_pkg;

    localparam logic [31:0] MH_MULT     = 32'h5bd1_e995;
    localparam int          MH_SH_WORD  = 24;
    localparam int          MH_SH_FIN_A = 13;
    localparam int          MH_SH_FIN_B = 15;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 3;
    localparam int KLEN_W  = 16;
    localparam int S_TDATA_W = 56;  // 51 bits of fields padded to bytes

    // operand that goes into the shared multiplier
    typedef enum logic [2:0] {
        MS_K      = 3'd0,   // k
        MS_K_MIX  = 3'd1,   // k ^ (k >> 24)
        MS_H      = 3'd2,   // h
        MS_H_TAIL = 3'd3,   // h ^ k (k holds the masked tail)
        MS_H_FIN  = 3'd4    // h ^ (h >> 13)
    } mul_sel_t;

    // source of the next running hash
    typedef enum logic [1:0] {
        HS_MIX = 2'd0,      // h*M ^ k
        HS_MUL = 2'd1,      // product alone
        HS_FIN = 2'd2       // h ^ (h >> 15)
    } h_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     k_we;
        logic     h_we;
        h_sel_t   h_sel;
        logic     out_load;
    } mh_cmd_t;

    typedef struct packed {
        logic in_full;
        logic in_part;
        logic in_last;
        logic last;
        logic out_busy;
    } mh_status_t;

    function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
        logic [31:0] m;
        case (cnt)
            2'd1:    m = 32'h0000_00ff;
            2'd2:    m = 32'h0000_ffff;
            2'd3:    m = 32'h00ff_ffff;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mh_datapath.sv =====
`default_nettype none

module mh_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [31:0]                  cfg_wr_data,
    input  wire logic [mh_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tuser,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [31:0]                       m_tdata,
    input  wire mh_pkg::mh_cmd_t              cmd,
    output mh_pkg::mh_status_t                status
);
    import mh_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic        last_reg;
    logic        out_valid_reg;
    logic [31:0] out_reg;

    logic [DATA_W-1:0]  in_word;
    logic [COUNT_W-1:0] in_count;
    logic [KLEN_W-1:0]  in_klen;
    logic [31:0]        in_masked;
    logic [31:0]        mul_in;
    logic [31:0]        mul_out;
    logic [31:0]        h_fin;

    assign in_word  = s_tdata[DATA_W-1:0];
    assign in_count = s_tdata[DATA_W+COUNT_W-1:DATA_W];
    assign in_klen  = s_tdata[DATA_W+COUNT_W+KLEN_W-1:DATA_W+COUNT_W];
    // counts of four and above take the whole word
    assign in_masked = in_count[2] ? in_word : (in_word & tail_mask(in_count[1:0]));

    always_comb
    begin
        case (cmd.mul_sel)
            MS_K:      mul_in = k_reg;
            MS_K_MIX:  mul_in = k_reg ^ (k_reg >> MH_SH_WORD);
            MS_H:      mul_in = h_reg;
            MS_H_TAIL: mul_in = h_reg ^ k_reg;
            MS_H_FIN:  mul_in = h_reg ^ (h_reg >> MH_SH_FIN_A);
            default:   mul_in = h_reg;
        endcase
    end

    assign mul_out = mul_in * MH_MULT;
    assign h_fin   = h_reg ^ (h_reg >> MH_SH_FIN_B);

    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        if (cmd.load)
        begin
            k_next = in_masked;
            if (s_tuser)
                h_next = seed_reg ^ {16'd0, in_klen};
        end
        if (cmd.k_we)
            k_next = mul_out;
        if (cmd.h_we)
        begin
            case (cmd.h_sel)
                HS_MIX:  h_next = mul_out ^ k_reg;
                HS_MUL:  h_next = mul_out;
                HS_FIN:  h_next = h_fin;
                default: h_next = h_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                seed_reg <= cfg_wr_data;
            h_reg <= h_next;
            if (cmd.load)
                last_reg <= s_tlast;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.out_load)
            out_reg <= h_fin;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign status.in_full  = in_count[2];
    assign status.in_part  = !in_count[2] && (in_count[1:0] != 2'd0);
    assign status.in_last  = s_tlast;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule

`default_nettype wire

// ===== hdl/mh_ctrl.sv =====
`default_nettype none

module mh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mh_pkg::mh_status_t status,
    output mh_pkg::mh_cmd_t         cmd
);
    import mh_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_MIXK1 = 7'b000_0010,
        ST_MIXK2 = 7'b000_0100,
        ST_MIXH  = 7'b000_1000,
        ST_TAIL  = 7'b001_0000,
        ST_FIN   = 7'b010_0000,
        ST_EMIT  = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.mul_sel  = MS_H;
        cmd.k_we     = 1'b0;
        cmd.h_we     = 1'b0;
        cmd.h_sel    = HS_MUL;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_full)
                        state_next = ST_MIXK1;
                    else if (status.in_part)
                        state_next = ST_TAIL;
                    else if (status.in_last)
                        state_next = ST_FIN;
                end
            end
            ST_MIXK1:
            begin
                cmd.mul_sel = MS_K;
                cmd.k_we    = 1'b1;
                state_next  = ST_MIXK2;
            end
            ST_MIXK2:
            begin
                cmd.mul_sel = MS_K_MIX;
                cmd.k_we    = 1'b1;
                state_next  = ST_MIXH;
            end
            ST_MIXH:
            begin
                cmd.mul_sel = MS_H;
                cmd.h_we    = 1'b1;
                cmd.h_sel   = HS_MIX;
                state_next  = status.last ? ST_FIN : ST_IDLE;
            end
            ST_TAIL:
            begin
                cmd.mul_sel = MS_H_TAIL;
                cmd.h_we    = 1'b1;
                cmd.h_sel   = HS_MUL;
                state_next  = status.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                cmd.mul_sel = MS_H_FIN;
                cmd.h_we    = 1'b1;
                cmd.h_sel   = HS_MUL;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.h_we     = 1'b1;
                    cmd.h_sel    = HS_FIN;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/murmur2_string_hash.sv =====
// MurmurHash2 (32-bit) of a byte key streamed as little-endian words, first
// byte in bits 7..0. An item with tuser set starts a key from seed ^ key_length;
// an item with tlast set finalizes the hash and returns it as one output item,
// held in an output register until taken. One 32x32 multiplier (low product
// bits) is shared by every multiply step, one multiply per cycle. A full word
// takes three multiplies after its load, a 1-3 byte tail one; a last item adds
// finalize and emit steps. The seed, which resets to zero, is written through
// cfg_wr_en/cfg_wr_data by the user only while idle; the block does not check it.
`default_nettype none

module murmur2_string_hash (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [31:0]                  cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // data_word[31:0], byte_count[34:32], key_length[50:35], zero pad
    input  wire logic [mh_pkg::S_TDATA_W-1:0] s_tdata,
    // first_item
    input  wire logic                         s_tuser,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // hash_value[31:0]
    output logic [31:0]                       m_tdata
);
    import mh_pkg::*;

    mh_cmd_t    cmd;
    mh_status_t status;

    mh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

// ===== tb/murmur2_string_hash_tb.sv =====
`default_nettype none

module murmur2_string_hash_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_CYCLES  = 16;    // covers a full word plus finalize
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASE_COUNT   = 8;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  count;
        logic        first;
        logic        last;
        logic [15:0] klen;
    } key_item_t;

    typedef struct {
        key_item_t   item;
        bit          typed;      // hash typed in below instead of predicted
        logic [31:0] hash;
    } key_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [31:0]                  cfg_wr_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mh_pkg::S_TDATA_W-1:0] s_tdata;
    logic                         s_tuser;
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [31:0]                  m_tdata;

    logic [31:0] seed_shadow;
    logic [31:0] key_hash;
    logic [31:0] hash_expected[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;

    murmur2_string_hash u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] murmur_fold_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] km;
        logic [31:0] hm;
        km = k * mh_pkg::MH_MULT;
        km = km ^ (km >> mh_pkg::MH_SH_WORD);
        km = km * mh_pkg::MH_MULT;
        hm = h * mh_pkg::MH_MULT;
        return hm ^ km;
    endfunction

    function automatic logic [31:0] murmur_finish(input logic [31:0] h);
        logic [31:0] f;
        f = h ^ (h >> mh_pkg::MH_SH_FIN_A);
        f = f * mh_pkg::MH_MULT;
        return f ^ (f >> mh_pkg::MH_SH_FIN_B);
    endfunction

    // advances key_hash by one item; returns 1 when the item emits a hash
    function automatic bit murmur_absorb(input key_item_t it, output logic [31:0] hash_out);
        logic [31:0] h;
        logic [31:0] mask;
        h = it.first ? (seed_shadow ^ {16'h0, it.klen}) : key_hash;
        if (it.count >= 3'd4)
            h = murmur_fold_word(h, it.word);
        else if (it.count != 3'd0)
        begin
            mask = (32'h1 << (8 * it.count)) - 32'h1;
            h = (h ^ (it.word & mask)) * mh_pkg::MH_MULT;
        end
        if (it.last)
            h = murmur_finish(h);
        key_hash = h;
        hash_out = h;
        return it.last;
    endfunction

    function automatic key_row_t row(input logic [31:0] word, input logic [2:0] count,
                                     input logic first, input logic last,
                                     input logic [15:0] klen, input bit typed,
                                     input logic [31:0] hash);
        key_row_t r;
        r.item.word  = word;
        r.item.count = count;
        r.item.first = first;
        r.item.last  = last;
        r.item.klen  = klen;
        r.typed      = typed;
        r.hash       = hash;
        return r;
    endfunction

    task automatic send_item(input key_item_t it, input bit typed, input logic [31:0] typed_hash);
        logic [31:0] h;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.klen, it.count, it.word};
        s_tuser  <= it.first;
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
        if (murmur_absorb(it, h))
            hash_expected.push_back(typed ? typed_hash : h);
        items_sent++;
    endtask

    task automatic send_random_key();
        key_item_t it;
        int        r;
        int        len;
        int        n;
        logic [15:0] klen;
        r = $urandom_range(99);
        if (r < 12)
        begin
            // noise: every field free, counts 5..7 included
            it.word  = $urandom;
            it.count = 3'($urandom_range(7));
            it.first = 1'($urandom_range(1));
            it.last  = 1'($urandom_range(1));
            it.klen  = 16'($urandom);
            send_item(it, 1'b0, 32'h0);
        end
        else
        begin
            len  = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(24);
            klen = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(len);
            n    = (len + 3) / 4;
            if (n == 0)
                n = 1;
            for (int i = 0; i < n; i++)
            begin
                it.word  = $urandom;
                it.first = (i == 0);
                // broken key: last item never flagged
                it.last  = (i == n - 1) && (r >= 18);
                if (len == 0)
                    it.count = 3'd0;
                else if (i == n - 1 && len % 4 != 0)
                    it.count = 3'(len % 4);
                else
                    it.count = 3'd4;
                it.klen  = (i == 0) ? klen : 16'($urandom);
                send_item(it, 1'b0, 32'h0);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        seed_shadow = value;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hash_expected.size() == 0)
            begin
                $error("unexpected output item: hash_value actual %h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = hash_expected.pop_front();
                if (m_tdata !== want)
                begin
                    $error("hash_value mismatch: expected %h, actual %h", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("murmur2_string_hash verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        key_row_t    directed_rows[$];
        logic [31:0] seeds[PHASE_COUNT];
        int          phase_budget;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 32'h0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        seed_shadow = 32'h0;
        key_hash    = 32'h0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_rows = '{
            // empty key under the reset seed hashes to zero
            row(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'h0000, 1'b1, 32'h0000_0000),
            row(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff, 1'b0, 32'h0),
            row(32'h0000_0000, 3'd4, 1'b1, 1'b1, 16'h0004, 1'b0, 32'h0),
            // tails with junk above the valid bytes
            row(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 16'h0001, 1'b0, 32'h0),
            row(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 16'h0002, 1'b0, 32'h0),
            row(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 16'h0003, 1'b0, 32'h0),
            // counts above four act as full words
            row(32'h1234_5678, 3'd5, 1'b1, 1'b0, 16'h000c, 1'b0, 32'h0),
            row(32'h9abc_def0, 3'd6, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0),
            row(32'h0f0f_0f0f, 3'd7, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            // tail in the middle of a key
            row(32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0, 16'h0006, 1'b0, 32'h0),
            row(32'h5a5a_5a5a, 3'd4, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            // empty middle item leaves the hash alone
            row(32'hdead_beef, 3'd4, 1'b1, 1'b0, 16'h0008, 1'b0, 32'h0),
            row(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 16'hffff, 1'b0, 32'h0),
            row(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            // no first item: continues from the last emitted hash
            row(32'h1357_9bdf, 3'd3, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            row(32'h0000_0000, 3'd0, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            // declared length disagrees with the bytes sent
            row(32'h1111_1111, 3'd4, 1'b1, 1'b0, 16'h0003, 1'b0, 32'h0),
            row(32'h2222_2222, 3'd4, 1'b0, 1'b0, 16'h0000, 1'b0, 32'h0),
            row(32'h3333_3333, 3'd4, 1'b0, 1'b1, 16'h0000, 1'b0, 32'h0),
            row(32'h8000_0000, 3'd4, 1'b1, 1'b1, 16'h8000, 1'b0, 32'h0),
            row(32'h0000_0001, 3'd1, 1'b1, 1'b1, 16'h0001, 1'b0, 32'h0)
        };
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].hash);

        seeds = '{32'hffff_ffff, $urandom, 32'h0000_0001, 32'h8000_0000,
                  32'h0000_0000, $urandom, $urandom, 32'hffff_ffff};
        phase_budget = RANDOM_ITEMS / PHASE_COUNT;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_seed(seeds[p]);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            items_sent = 0;
            // long output hold-off while items keep coming, fills the block
            if (p == 0)
                hold_req = 1'b1;
            while (items_sent < phase_budget)
                send_random_key();
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("murmur2_string_hash verification clean");
        else
            $display("murmur2_string_hash verification failed");
        $finish;
    end

endmodule

`default_nettype wire
